// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by the controller and datapath RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property checked on every clock edge outside reset.
`define AST_PROP(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define AST_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`else

`define AST_PROP(lbl, clk, rstn, prop, msg)
`define AST_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

// ===== hw/rtl/nhtl_pkg.sv =====
package nhtl_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int IDX_W    = 8;
    localparam int HASH_W   = 32;
    localparam int BYTE_W   = 8;
    localparam int ECNT_W   = 9;
    localparam int SUM_W    = 20;
    localparam int XOR_W    = 12;
    localparam int CIDX_W   = 12;

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 40;

    localparam logic [BYTE_W-1:0] FOLD_LO   = 8'h61;
    localparam logic [BYTE_W-1:0] FOLD_SPAN = 8'h1A;
    localparam logic [BYTE_W-1:0] FOLD_MASK = 8'hDF;

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_NAME = 1'b1
    } nhtl_cmd_t;

    // controller -> datapath
    typedef struct packed {
        logic load_en;
        logic byte_en;
        logic scan_start;
        logic scan_run;
    } nhtl_ctl_t;

    // datapath -> controller
    typedef struct packed {
        logic term_item;
        logic scan_done;
    } nhtl_sts_t;

    // lower-case letters fold to upper case
    function automatic logic [BYTE_W-1:0] fold_byte(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] ofs;
        ofs = b - FOLD_LO;
        return (ofs < FOLD_SPAN) ? (b & FOLD_MASK) : b;
    endfunction

endpackage

// ===== hw/rtl/nhtl_ram.sv =====
module nhtl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                                          aclk,
    input  logic                                          we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
    input  logic [WIDTH-1:0]                              wdata,
    input  logic                                          re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
    output logic [WIDTH-1:0]                              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hw/rtl/nhtl_ctrl.sv =====
`include "assert_macros.svh"

module nhtl_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic                s_axis_tuser,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    input  nhtl_pkg::nhtl_sts_t sts,
    output nhtl_pkg::nhtl_ctl_t ctl
);
    import nhtl_pkg::*;

    typedef enum logic [2:0] {
        S_RUN  = 3'b001,
        S_SCAN = 3'b010,
        S_OUT  = 3'b100
    } nhtl_state_t;

    nhtl_state_t state_reg, state_next;
    logic        fire;
    logic        is_load;

    assign is_load = (nhtl_cmd_t'(s_axis_tuser) == CMD_LOAD);

    // loads and name bytes may enter while a result waits; a terminator may not
    always_comb begin
        s_axis_tready = 1'b0;
        case (state_reg)
            S_RUN:   s_axis_tready = 1'b1;
            S_OUT:   s_axis_tready = !sts.term_item;
            default: s_axis_tready = 1'b0;
        endcase
    end

    assign fire          = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = (state_reg == S_OUT);

    always_comb begin
        ctl.load_en    = fire && is_load;
        ctl.byte_en    = fire && !is_load && !sts.term_item;
        ctl.scan_start = fire && sts.term_item;
        ctl.scan_run   = (state_reg == S_SCAN);
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_RUN: begin
                if (ctl.scan_start) begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                if (sts.scan_done) begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (m_axis_tready) begin
                    state_next = S_RUN;
                end
            end
            default: state_next = S_RUN;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_RUN;
        end else begin
            state_reg <= state_next;
        end
    end

    `AST_NEVER(a_no_input_in_scan, aclk, aresetn, (state_reg == S_SCAN) && s_axis_tready, "input taken during scan")
    `AST_NEVER(a_no_term_while_out, aclk, aresetn, m_axis_tvalid && sts.term_item && s_axis_tready, "terminator taken while result pending")
    `AST_PROP(a_start_to_scan, aclk, aresetn, ctl.scan_start |=> (state_reg == S_SCAN), "scan did not start")

endmodule

// ===== hw/rtl/nhtl_dp.sv =====
`include "assert_macros.svh"

module nhtl_dp (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [nhtl_pkg::ECNT_W-1:0]       cfg_wdata,
    input  logic [nhtl_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    input  logic                              s_axis_tuser,
    output logic [nhtl_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    output logic                              m_axis_tuser,
    input  nhtl_pkg::nhtl_ctl_t               ctl,
    output nhtl_pkg::nhtl_sts_t               sts
);
    import nhtl_pkg::*;

    logic [IDX_W-1:0]  entry_index;
    logic [HASH_W-1:0] entry_hash;
    logic [BYTE_W-1:0] name_byte;
    logic [BYTE_W-1:0] fold_c;
    logic [XOR_W-1:0]  prod;
    logic [HASH_W-1:0] cur_hash;
    logic [CNT_W-1:0]  lim;

    logic [ECNT_W-1:0] entry_count_reg;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [XOR_W-1:0]  xor_reg, xor_next;
    logic [CIDX_W-1:0] cidx_reg, cidx_next;
    logic [HASH_W-1:0] hash_reg, hash_next;
    logic [CNT_W-1:0]  limit_reg, limit_next;
    logic [CNT_W-1:0]  issue_reg, issue_next;
    logic              cmp_vld_reg, cmp_vld_next;
    logic [ADDR_W-1:0] cmp_slot_reg, cmp_slot_next;
    logic              found_reg, found_next;
    logic [IDX_W-1:0]  slot_reg, slot_next;

    logic              wr_en;
    logic              rd_issue;
    logic [HASH_W-1:0] rd_data;

    assign entry_index = s_axis_tdata[7:0];
    assign entry_hash  = s_axis_tdata[39:8];
    assign name_byte   = s_axis_tdata[47:40];

    assign fold_c   = fold_byte(name_byte);
    assign prod     = XOR_W'(fold_c) * cidx_reg;
    assign cur_hash = {cidx_reg[7:0], 24'b0} | {sum_reg, 12'b0} | {20'b0, xor_reg};

    always_comb begin
        if (int'(entry_count_reg) > TABLE_DEPTH) begin
            lim = CNT_W'(TABLE_DEPTH);
        end else begin
            lim = CNT_W'(entry_count_reg);
        end
    end

    assign sts.term_item = (nhtl_cmd_t'(s_axis_tuser) == CMD_NAME) && (name_byte == '0);
    assign sts.scan_done = found_reg || ((issue_reg == limit_reg) && !cmp_vld_reg);

    assign wr_en    = ctl.load_en && (int'(entry_index) < TABLE_DEPTH);
    assign rd_issue = ctl.scan_run && !found_reg && (issue_reg != limit_reg);

    nhtl_ram #(
        .WIDTH (HASH_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (ADDR_W'(entry_index)),
        .wdata (entry_hash),
        .re    (rd_issue),
        .raddr (issue_reg[ADDR_W-1:0]),
        .rdata (rd_data)
    );

    always_comb begin
        sum_next      = sum_reg;
        xor_next      = xor_reg;
        cidx_next     = cidx_reg;
        hash_next     = hash_reg;
        limit_next    = limit_reg;
        issue_next    = issue_reg;
        cmp_vld_next  = 1'b0;
        cmp_slot_next = cmp_slot_reg;
        found_next    = found_reg;
        slot_next     = slot_reg;

        if (ctl.byte_en) begin
            sum_next  = sum_reg + SUM_W'(fold_c);
            xor_next  = xor_reg ^ prod;
            cidx_next = cidx_reg + CIDX_W'(1);
        end

        if (ctl.scan_start) begin
            hash_next  = cur_hash;
            sum_next   = '0;
            xor_next   = '0;
            cidx_next  = '0;
            limit_next = lim;
            issue_next = '0;
            found_next = 1'b0;
            slot_next  = '0;
        end

        // one read issued per cycle, compared when the registered data returns
        if (rd_issue) begin
            issue_next    = issue_reg + CNT_W'(1);
            cmp_vld_next  = 1'b1;
            cmp_slot_next = issue_reg[ADDR_W-1:0];
        end

        if (ctl.scan_run && cmp_vld_reg && !found_reg && (rd_data == hash_reg)) begin
            found_next = 1'b1;
            slot_next  = IDX_W'(cmp_slot_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_count_reg <= '0;
            sum_reg         <= '0;
            xor_reg         <= '0;
            cidx_reg        <= '0;
            limit_reg       <= '0;
            issue_reg       <= '0;
            cmp_vld_reg     <= 1'b0;
            found_reg       <= 1'b0;
            slot_reg        <= '0;
        end else begin
            if (cfg_we) begin
                entry_count_reg <= cfg_wdata;
            end
            sum_reg     <= sum_next;
            xor_reg     <= xor_next;
            cidx_reg    <= cidx_next;
            limit_reg   <= limit_next;
            issue_reg   <= issue_next;
            cmp_vld_reg <= cmp_vld_next;
            found_reg   <= found_next;
            slot_reg    <= slot_next;
        end
    end

    always_ff @(posedge aclk) begin
        hash_reg     <= hash_next;
        cmp_slot_reg <= cmp_slot_next;
    end

    assign m_axis_tdata = {slot_reg, hash_reg};
    assign m_axis_tuser = found_reg;

    `AST_PROP(a_issue_in_range, aclk, aresetn, issue_reg <= limit_reg, "read pointer past limit")
    `AST_PROP(a_hit_sticks, aclk, aresetn, (ctl.scan_run && found_reg) |=> found_reg, "hit lost during scan")
    `AST_PROP(a_miss_slot_zero, aclk, aresetn, !found_reg |-> (slot_reg == '0), "slot set without hit")

endmodule

// ===== hw/rtl/name_hash_table_lookup.sv =====
// Channel   Dir  Handshake                 Payload
// cfg       in   cfg_we                    cfg_wdata = entry_count
// s_axis    in   s_axis_tvalid/tready      tuser = cmd; tdata = index, hash, byte
// m_axis    out  m_axis_tvalid/tready      tuser = found; tdata = result hash, slot_index
//
// Load items and nonzero name bytes are accepted whenever no scan is running.
// A terminator starts a table scan through the RAM read port, one slot per cycle,
// covering min(entry_count, depth) slots and stopping at the first slot whose hash matches.
// Loads and name bytes keep flowing while a result waits; a terminator waits.
// aresetn clears the accumulators and entry_count; the table needs no clearing pass.
module name_hash_table_lookup (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [nhtl_pkg::ECNT_W-1:0]       cfg_wdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [nhtl_pkg::S_TDATA_W-1:0]    s_axis_tdata,  // entry_index, entry_hash, name_byte
    input  logic                              s_axis_tuser,  // cmd
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [nhtl_pkg::M_TDATA_W-1:0]    m_axis_tdata,  // result hash, slot_index
    output logic                              m_axis_tuser   // found
);
    import nhtl_pkg::*;

    nhtl_ctl_t ctl;
    nhtl_sts_t sts;

    nhtl_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .sts           (sts),
        .ctl           (ctl)
    );

    nhtl_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .ctl          (ctl),
        .sts          (sts)
    );

endmodule
